>>> rtl/core/envelope_generator_curve_table_defines.svh
// Assertion macros for the envelope generator RTL.
// Depends on nothing; a user module must have clk and rst_n in scope.
`ifndef ENVELOPE_GENERATOR_CURVE_TABLE_DEFINES_SVH
`define ENVELOPE_GENERATOR_CURVE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define EGCT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("envelope generator assertion failed");
`define EGCT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("envelope generator assertion failed");
`else
`define EGCT_ASSERT_IMP(name, ante, cons)
`define EGCT_ASSERT_NXT(name, ante, cons)
`endif
`endif

>>> rtl/core/egct_pkg.sv
// Shared types, constants and the curve ROM of the envelope generator.
// Depends on nothing.
package egct_pkg;

  localparam int POINTS      = 32;
  localparam int ADDR_W      = $clog2(POINTS);
  localparam int CURVE_STEPS = 16;
  localparam int MAX_HOPS    = 8;
  localparam int HOP_W       = $clog2(MAX_HOPS + 1);
  localparam int POINT_W     = 35;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_START   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_STOP    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_HOLD    = 3'd2,
    PH_RELEASE = 3'd3,
    PH_DIRECT  = 3'd4
  } phase_t;

  localparam logic [3:0] KIND_JUMP = 4'hD;
  localparam logic [3:0] KIND_HOLD = 4'hE;
  localparam logic [3:0] KIND_STOP = 4'hF;

  localparam logic [2:0] CFG_RATE      = 3'd0;
  localparam logic [2:0] CFG_SCALE     = 3'd1;
  localparam logic [2:0] CFG_OFFSET    = 3'd2;
  localparam logic [2:0] CFG_DIRECT    = 3'd3;
  localparam logic [2:0] CFG_ATTACK    = 3'd4;
  localparam logic [2:0] CFG_REL_MODE  = 3'd5;
  localparam logic [2:0] CFG_REL_BASE  = 3'd6;

  localparam logic [1:0] RM_REGION   = 2'd1;
  localparam logic [1:0] RM_CONTINUE = 2'd2;

  localparam logic signed [15:0] FULL_LEVEL = 16'sd32767;

  typedef struct packed {
    logic [3:0]         kind;
    logic [14:0]        dur;
    logic signed [15:0] lvl;
  } point_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LATCH, OP_LOAD_PT, OP_START_HOLD, OP_RD_P0, OP_START_TBL,
    OP_REL_DIRECT, OP_REL_STOP, OP_RD_RELBASE, OP_REL_TBL, OP_REL_CONT,
    OP_TICK_MUL, OP_TICK_ADD, OP_DIR_DONE, OP_DIR_BLEND, OP_TO_HOLD,
    OP_RD_SEG, OP_HOP, OP_WALK_BLEND, OP_STOP, OP_JUMP, OP_CURVE,
    OP_DIV_INIT, OP_DIV_STEP, OP_W1, OP_W2, OP_W3, OP_L1, OP_L2, OP_L3,
    OP_O1, OP_O2, OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_START_RD, S_REL_RD, S_TICK_ADD, S_ADV, S_WALK,
    S_WALK_NEXT, S_DIV_INIT, S_DIV, S_W1, S_W2, S_W3, S_L1, S_L2, S_L3,
    S_O1, S_O2, S_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    phase_t     phase;
    logic       attack_mode;
    logic [1:0] release_mode;
    logic       direct_nz;
    logic       rel_tabled;
    logic       tabled;
    logic       dir_live;
    logic       walk_go;
    logic [3:0] rd_kind;
    logic       div_clamp;
    logic       div_last;
    logic       out_free;
  } dp_stat_t;

  localparam logic [15:0] CURVE_ROM [4][CURVE_STEPS + 1] = '{
    '{16'd32768, 16'd30720, 16'd28672, 16'd26624, 16'd24576, 16'd22528,
      16'd20480, 16'd18432, 16'd16384, 16'd14336, 16'd12288, 16'd10240,
      16'd8192, 16'd6144, 16'd4096, 16'd2048, 16'd0},
    '{16'd32768, 16'd31727, 16'd30652, 16'd29537, 16'd28378, 16'd27170,
      16'd25905, 16'd24576, 16'd23170, 16'd21675, 16'd20066, 16'd18318,
      16'd16384, 16'd14189, 16'd11585, 16'd8192, 16'd0},
    '{16'd32768, 16'd28800, 16'd25088, 16'd21632, 16'd18432, 16'd15488,
      16'd12800, 16'd10368, 16'd8192, 16'd6272, 16'd4608, 16'd3200,
      16'd2048, 16'd1152, 16'd512, 16'd128, 16'd0},
    '{16'd32768, 16'd31801, 16'd25601, 16'd17901, 16'd13100, 16'd9480,
      16'd6950, 16'd5160, 16'd3690, 16'd2680, 16'd1900, 16'd1430,
      16'd1010, 16'd777, 16'd500, 16'd300, 16'd0}
  };

  function automatic logic [15:0] curve_rom(input logic [1:0] sel, input logic [4:0] idx);
    logic [15:0] v;
    if (idx > 5'(CURVE_STEPS)) begin
      v = CURVE_ROM[sel][CURVE_STEPS];
    end else begin
      v = CURVE_ROM[sel][idx];
    end
    return v;
  endfunction

endpackage

>>> rtl/core/envelope_generator_curve_table.sv
// Envelope generator top level: ties the sequencer to the datapath.
// Depends on egct_pkg, egct_ctrl and egct_dp.
//
// Requests enter on the in_ channel (valid/stall); each one yields exactly one
// result (level, phase) on the out_ channel (valid/stall). Commands are tick,
// start, release and load point. Configuration registers are written through
// the cfg_ channel (valid/ready, ready always high); the user must write them
// only while no request is open, as the block itself does not enforce this.
// The block works on one request at a time. A load, an idle tick, a start
// without a table or a release that only stops goes straight to output
// scaling; a start from the table first reads point 0. An active tick updates
// the counter, locates the current point, walks each expired point (at most
// eight), runs the 16-step restoring divider that finds the curve position
// (skipped when it sits at the segment end), then does weight, blend and
// output scaling. A release from the table walks the same way.
// A finished result sits in the output register; the next request is already
// accepted while it waits, and the block stalls only at its own hand-over.
// Synchronous reset clears the envelope state to stopped and loads the
// register defaults; the point RAM is not cleared and must be loaded first.
module envelope_generator_curve_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [15:0]        in_tick_amount,
  input  logic [4:0]         in_point_index,
  input  logic [3:0]         in_point_kind,
  input  logic [14:0]        in_point_duration,
  input  logic signed [15:0] in_point_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_level,
  output logic [2:0]         out_phase,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  egct_pkg::ctl_cmd_t ctl_cmd;
  egct_pkg::dp_stat_t dp_stat;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  egct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  egct_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (ctl_cmd),
    .stat              (dp_stat),
    .in_cmd            (in_cmd),
    .in_tick_amount    (in_tick_amount),
    .in_point_index    (in_point_index),
    .in_point_kind     (in_point_kind),
    .in_point_duration (in_point_duration),
    .in_point_level    (in_point_level),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level         (out_level),
    .out_phase         (out_phase)
  );

endmodule

>>> rtl/core/egct_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module egct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/egct_ctrl.sv
// Sequencer of the envelope generator: issues one datapath operation per cycle.
// Depends on egct_pkg and envelope_generator_curve_table_defines.svh.
`include "envelope_generator_curve_table_defines.svh"
module egct_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  egct_pkg::dp_stat_t stat,
  output egct_pkg::ctl_cmd_t cmd
);

  egct_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= egct_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = egct_pkg::OP_NONE;
    in_stall  = 1'b1;
    unique case (state_r)
      egct_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = egct_pkg::OP_LATCH;
          state_nxt = egct_pkg::S_DISPATCH;
        end
      end
      egct_pkg::S_DISPATCH: begin
        unique case (stat.cmd)
          egct_pkg::CMD_LOAD: begin
            cmd.op    = egct_pkg::OP_LOAD_PT;
            state_nxt = egct_pkg::S_O1;
          end
          egct_pkg::CMD_START: begin
            if (!stat.attack_mode) begin
              cmd.op    = egct_pkg::OP_START_HOLD;
              state_nxt = egct_pkg::S_O1;
            end else begin
              cmd.op    = egct_pkg::OP_RD_P0;
              state_nxt = egct_pkg::S_START_RD;
            end
          end
          egct_pkg::CMD_RELEASE: begin
            if (stat.direct_nz) begin
              cmd.op    = egct_pkg::OP_REL_DIRECT;
              state_nxt = egct_pkg::S_ADV;
            end else if (!stat.rel_tabled) begin
              cmd.op    = egct_pkg::OP_REL_STOP;
              state_nxt = egct_pkg::S_O1;
            end else if (stat.release_mode == egct_pkg::RM_REGION) begin
              cmd.op    = egct_pkg::OP_RD_RELBASE;
              state_nxt = egct_pkg::S_REL_RD;
            end else begin
              cmd.op    = egct_pkg::OP_REL_CONT;
              state_nxt = egct_pkg::S_ADV;
            end
          end
          egct_pkg::CMD_TICK: begin
            if (stat.phase == egct_pkg::PH_ATTACK || stat.phase == egct_pkg::PH_RELEASE ||
                stat.phase == egct_pkg::PH_DIRECT) begin
              cmd.op    = egct_pkg::OP_TICK_MUL;
              state_nxt = egct_pkg::S_TICK_ADD;
            end else begin
              state_nxt = egct_pkg::S_O1;
            end
          end
          default: state_nxt = egct_pkg::S_O1;
        endcase
      end
      egct_pkg::S_START_RD: begin
        cmd.op    = egct_pkg::OP_START_TBL;
        state_nxt = egct_pkg::S_O1;
      end
      egct_pkg::S_REL_RD: begin
        cmd.op    = egct_pkg::OP_REL_TBL;
        state_nxt = egct_pkg::S_ADV;
      end
      egct_pkg::S_TICK_ADD: begin
        cmd.op    = egct_pkg::OP_TICK_ADD;
        state_nxt = egct_pkg::S_ADV;
      end
      egct_pkg::S_ADV: begin
        priority if (stat.phase == egct_pkg::PH_DIRECT) begin
          if (stat.dir_live) begin
            cmd.op    = egct_pkg::OP_DIR_BLEND;
            state_nxt = egct_pkg::S_DIV_INIT;
          end else begin
            cmd.op    = egct_pkg::OP_DIR_DONE;
            state_nxt = egct_pkg::S_O1;
          end
        end else if (stat.phase != egct_pkg::PH_ATTACK &&
                     stat.phase != egct_pkg::PH_RELEASE) begin
          state_nxt = egct_pkg::S_O1;
        end else if (!stat.tabled) begin
          cmd.op    = egct_pkg::OP_TO_HOLD;
          state_nxt = egct_pkg::S_O1;
        end else begin
          cmd.op    = egct_pkg::OP_RD_SEG;
          state_nxt = egct_pkg::S_WALK;
        end
      end
      egct_pkg::S_WALK: begin
        if (stat.walk_go) begin
          cmd.op    = egct_pkg::OP_HOP;
          state_nxt = egct_pkg::S_WALK_NEXT;
        end else begin
          cmd.op    = egct_pkg::OP_WALK_BLEND;
          state_nxt = egct_pkg::S_DIV_INIT;
        end
      end
      egct_pkg::S_WALK_NEXT: begin
        priority if (stat.rd_kind == egct_pkg::KIND_STOP) begin
          cmd.op    = egct_pkg::OP_STOP;
          state_nxt = egct_pkg::S_O1;
        end else if (stat.rd_kind == egct_pkg::KIND_HOLD) begin
          cmd.op    = egct_pkg::OP_TO_HOLD;
          state_nxt = egct_pkg::S_O1;
        end else if (stat.rd_kind == egct_pkg::KIND_JUMP) begin
          cmd.op    = egct_pkg::OP_JUMP;
          state_nxt = egct_pkg::S_WALK;
        end else begin
          cmd.op    = egct_pkg::OP_CURVE;
          state_nxt = egct_pkg::S_WALK;
        end
      end
      egct_pkg::S_DIV_INIT: begin
        cmd.op    = egct_pkg::OP_DIV_INIT;
        state_nxt = stat.div_clamp ? egct_pkg::S_W1 : egct_pkg::S_DIV;
      end
      egct_pkg::S_DIV: begin
        cmd.op = egct_pkg::OP_DIV_STEP;
        if (stat.div_last) begin
          state_nxt = egct_pkg::S_W1;
        end
      end
      egct_pkg::S_W1: begin
        cmd.op    = egct_pkg::OP_W1;
        state_nxt = egct_pkg::S_W2;
      end
      egct_pkg::S_W2: begin
        cmd.op    = egct_pkg::OP_W2;
        state_nxt = egct_pkg::S_W3;
      end
      egct_pkg::S_W3: begin
        cmd.op    = egct_pkg::OP_W3;
        state_nxt = egct_pkg::S_L1;
      end
      egct_pkg::S_L1: begin
        cmd.op    = egct_pkg::OP_L1;
        state_nxt = egct_pkg::S_L2;
      end
      egct_pkg::S_L2: begin
        cmd.op    = egct_pkg::OP_L2;
        state_nxt = egct_pkg::S_L3;
      end
      egct_pkg::S_L3: begin
        cmd.op    = egct_pkg::OP_L3;
        state_nxt = egct_pkg::S_O1;
      end
      egct_pkg::S_O1: begin
        cmd.op    = egct_pkg::OP_O1;
        state_nxt = egct_pkg::S_O2;
      end
      egct_pkg::S_O2: begin
        cmd.op    = egct_pkg::OP_O2;
        state_nxt = egct_pkg::S_EMIT;
      end
      egct_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = egct_pkg::OP_EMIT;
          state_nxt = egct_pkg::S_IDLE;
        end
      end
      default: state_nxt = egct_pkg::S_IDLE;
    endcase
  end

  // An accepted request always goes to dispatch next.
  `EGCT_ASSERT_NXT(a_accept_dispatch, in_valid && !in_stall, state_r == egct_pkg::S_DISPATCH)
  // A result is only handed over when the output register is free.
  `EGCT_ASSERT_IMP(a_emit_free, cmd.op == egct_pkg::OP_EMIT, stat.out_free)
  // The point kind check always follows a hop.
  `EGCT_ASSERT_IMP(a_hop_before_kind, state_r == egct_pkg::S_WALK_NEXT,
                   $past(cmd.op) == egct_pkg::OP_HOP)
  // After handing over a result the sequencer is ready again.
  `EGCT_ASSERT_NXT(a_emit_idle, cmd.op == egct_pkg::OP_EMIT, !in_stall)

endmodule

>>> rtl/core/egct_dp.sv
// Datapath of the envelope generator: registers, point RAM, shared multiplier, divider.
// Depends on egct_pkg and egct_ram.
module egct_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  egct_pkg::ctl_cmd_t    cmd,
  output egct_pkg::dp_stat_t    stat,
  input  logic [1:0]            in_cmd,
  input  logic [15:0]           in_tick_amount,
  input  logic [4:0]            in_point_index,
  input  logic [3:0]            in_point_kind,
  input  logic [14:0]           in_point_duration,
  input  logic signed [15:0]    in_point_level,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_level,
  output logic [2:0]            out_phase
);

  // Configuration registers.
  logic [15:0]        rate_r;
  logic signed [15:0] scale_r, offset_r;
  logic [15:0]        direct_r;
  logic               am_r;
  logic [1:0]         rm_r;
  logic [4:0]         rb_r;

  // Latched request.
  egct_pkg::cmd_t     cmd_r;
  logic [15:0]        tick_r;
  logic [4:0]         pidx_r;
  logic [3:0]         pkind_r;
  logic [14:0]        pdur_r;
  logic signed [15:0] plvl_r;

  // Envelope state.
  logic [31:0]                  tc_r, tc_nxt;
  logic [egct_pkg::ADDR_W-1:0]  seg_r, seg_nxt;
  logic [1:0]                   csel_r, csel_nxt;
  logic signed [15:0]           start_r, start_nxt, target_r, target_nxt, cur_r, cur_nxt;
  egct_pkg::phase_t             phase_r, phase_nxt;
  logic [egct_pkg::HOP_W-1:0]   hops_r, hops_nxt;
  logic [3:0]                   div_cnt_r, div_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Work registers.
  logic signed [39:0] acc_r, acc_nxt;
  logic [16:0]        p_r, p_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [14:0]        divd_r, divd_nxt;
  logic [15:0]        w_r, w_nxt;
  logic signed [15:0] sat_r, sat_nxt;
  logic signed [15:0] out_level_r;
  logic [2:0]         out_phase_r;

  // Point RAM.
  logic                           ram_we, ram_re;
  logic [egct_pkg::ADDR_W-1:0]    ram_raddr, base;
  logic [egct_pkg::POINT_W-1:0]   ram_rdata;
  egct_pkg::point_t               rd, wpt;

  assign wpt = '{kind: pkind_r, dur: pdur_r, lvl: plvl_r};
  assign rd  = egct_pkg::point_t'(ram_rdata);

  egct_ram #(
    .WIDTH (egct_pkg::POINT_W),
    .DEPTH (egct_pkg::POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (egct_pkg::ADDR_W'(pidx_r)),
    .wdata (wpt),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared multiplier and helpers.
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;
  logic [4:0]         ci, ci1;
  logic [11:0]        frac;
  logic [15:0]        t_i, t_i1;
  logic [13:0]        dir_x;
  logic               rel_tabled;
  logic [32:0]        tc_sum;
  logic [16:0]        rem2;
  logic               ge;
  logic signed [39:0] wsum, lsum, osum;
  logic signed [23:0] ov;

  assign frac = p_r[11:0];
  assign ci   = p_r[16:12];
  assign ci1  = (ci >= 5'(egct_pkg::CURVE_STEPS)) ? 5'(egct_pkg::CURVE_STEPS) : ci + 5'd1;
  assign t_i  = egct_pkg::curve_rom(csel_r, ci);
  assign t_i1 = egct_pkg::curve_rom(csel_r, ci1);
  assign dir_x = direct_r[13:0];
  assign rel_tabled = (rm_r == egct_pkg::RM_REGION) ||
                      (rm_r == egct_pkg::RM_CONTINUE && am_r);
  assign base = (phase_r != egct_pkg::PH_ATTACK && rm_r == egct_pkg::RM_REGION) ?
                egct_pkg::ADDR_W'(rb_r) : '0;
  assign prod   = mul_a * mul_b;
  assign tc_sum = {1'b0, tc_r} + {1'b0, acc_r[31:0]};
  assign rem2   = {rem_r, p_r[15]};
  assign ge     = rem2 >= {2'b00, divd_r};
  assign wsum   = acc_r + 40'sd2048;
  assign lsum   = acc_r + 40'sd16384;
  assign osum   = acc_r + 40'sd2048;
  assign ov     = osum[35:12] + {{8{offset_r[15]}}, offset_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      egct_pkg::OP_TICK_MUL: begin
        mul_a = {2'b00, tick_r};
        mul_b = {2'b00, rate_r};
      end
      egct_pkg::OP_W1: begin
        mul_a = {5'b0, 13'(13'd4096 - {1'b0, frac})};
        mul_b = {2'b00, t_i};
      end
      egct_pkg::OP_W2: begin
        mul_a = {6'b0, frac};
        mul_b = {2'b00, t_i1};
      end
      egct_pkg::OP_L1: begin
        mul_a = {{2{start_r[15]}}, start_r};
        mul_b = {2'b00, w_r};
      end
      egct_pkg::OP_L2: begin
        mul_a = {{2{target_r[15]}}, target_r};
        mul_b = {2'b00, 16'(17'd32768 - {1'b0, w_r})};
      end
      egct_pkg::OP_O1: begin
        mul_a = {{2{cur_r[15]}}, cur_r};
        mul_b = {{2{scale_r[15]}}, scale_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    tc_nxt = tc_r; seg_nxt = seg_r; csel_nxt = csel_r;
    start_nxt = start_r; target_nxt = target_r; cur_nxt = cur_r;
    phase_nxt = phase_r; hops_nxt = hops_r; div_cnt_nxt = div_cnt_r;
    acc_nxt = acc_r; p_nxt = p_r; rem_nxt = rem_r; divd_nxt = divd_r;
    w_nxt = w_r; sat_nxt = sat_r;
    ram_we = 1'b0; ram_re = 1'b0; ram_raddr = '0;
    unique case (cmd.op)
      egct_pkg::OP_LOAD_PT: ram_we = 32'(pidx_r) < egct_pkg::POINTS;
      egct_pkg::OP_START_HOLD: begin
        tc_nxt = '0; seg_nxt = '0; start_nxt = '0;
        cur_nxt = egct_pkg::FULL_LEVEL; phase_nxt = egct_pkg::PH_HOLD;
      end
      egct_pkg::OP_RD_P0: begin
        ram_re = 1'b1; ram_raddr = '0;
      end
      egct_pkg::OP_START_TBL: begin
        tc_nxt = '0; seg_nxt = '0; start_nxt = '0; cur_nxt = '0;
        target_nxt = rd.lvl; csel_nxt = rd.kind[1:0]; phase_nxt = egct_pkg::PH_ATTACK;
      end
      egct_pkg::OP_REL_DIRECT: begin
        tc_nxt = '0; start_nxt = cur_r; target_nxt = '0; seg_nxt = '0;
        csel_nxt = direct_r[15:14]; phase_nxt = egct_pkg::PH_DIRECT;
      end
      egct_pkg::OP_REL_STOP, egct_pkg::OP_STOP: phase_nxt = egct_pkg::PH_STOP;
      egct_pkg::OP_RD_RELBASE: begin
        ram_re = 1'b1; ram_raddr = egct_pkg::ADDR_W'(rb_r);
      end
      egct_pkg::OP_REL_TBL: begin
        tc_nxt = '0; start_nxt = cur_r; target_nxt = rd.lvl; seg_nxt = '0;
        csel_nxt = rd.kind[1:0]; phase_nxt = egct_pkg::PH_RELEASE;
      end
      egct_pkg::OP_REL_CONT: phase_nxt = egct_pkg::PH_RELEASE;
      egct_pkg::OP_TICK_MUL, egct_pkg::OP_W1, egct_pkg::OP_L1, egct_pkg::OP_O1:
        acc_nxt = 40'(prod);
      egct_pkg::OP_W2, egct_pkg::OP_L2: acc_nxt = acc_r + 40'(prod);
      egct_pkg::OP_TICK_ADD: tc_nxt = tc_sum[32] ? 32'hFFFF_FFFF : tc_sum[31:0];
      egct_pkg::OP_DIR_DONE: begin
        cur_nxt = target_r; phase_nxt = egct_pkg::PH_STOP;
      end
      egct_pkg::OP_DIR_BLEND: divd_nxt = {1'b0, dir_x};
      egct_pkg::OP_TO_HOLD: phase_nxt = egct_pkg::PH_HOLD;
      egct_pkg::OP_RD_SEG: begin
        hops_nxt = '0; ram_re = 1'b1; ram_raddr = base + seg_r;
      end
      egct_pkg::OP_HOP: begin
        tc_nxt = tc_r - {1'b0, rd.dur, 16'h0000};
        cur_nxt = target_r; start_nxt = target_r;
        seg_nxt = seg_r + 1'b1; hops_nxt = hops_r + 1'b1;
        ram_re = 1'b1; ram_raddr = base + seg_r + 1'b1;
      end
      egct_pkg::OP_WALK_BLEND: divd_nxt = rd.dur;
      egct_pkg::OP_JUMP: begin
        seg_nxt = rd.lvl[egct_pkg::ADDR_W-1:0];
        ram_re = 1'b1; ram_raddr = base + rd.lvl[egct_pkg::ADDR_W-1:0];
      end
      egct_pkg::OP_CURVE: begin
        csel_nxt = rd.kind[1:0]; target_nxt = rd.lvl;
      end
      egct_pkg::OP_DIV_INIT: begin
        rem_nxt = tc_r[31:16]; div_cnt_nxt = '0;
        p_nxt = stat.div_clamp ? 17'h10000 : {1'b0, tc_r[15:0]};
      end
      egct_pkg::OP_DIV_STEP: begin
        rem_nxt = ge ? 16'(rem2 - {2'b00, divd_r}) : rem2[15:0];
        p_nxt = {1'b0, p_r[14:0], ge};
        div_cnt_nxt = div_cnt_r + 4'd1;
      end
      egct_pkg::OP_W3: w_nxt = wsum[27:12];
      egct_pkg::OP_L3: cur_nxt = lsum[30:15];
      egct_pkg::OP_O2: begin
        priority if (ov > 24'sd32767) begin
          sat_nxt = 16'sd32767;
        end else if (ov < -24'sd32768) begin
          sat_nxt = -16'sd32768;
        end else begin
          sat_nxt = ov[15:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = (cmd.op == egct_pkg::OP_EMIT) ? 1'b1 :
                         (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 16'd256; scale_r <= 16'sd4096; offset_r <= '0; direct_r <= '0;
      am_r <= 1'b0; rm_r <= '0; rb_r <= 5'd16;
      tc_r <= '0; seg_r <= '0; csel_r <= '0; start_r <= '0; target_r <= '0;
      cur_r <= '0; phase_r <= egct_pkg::PH_STOP; hops_r <= '0; div_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          egct_pkg::CFG_RATE:     rate_r   <= cfg_data;
          egct_pkg::CFG_SCALE:    scale_r  <= cfg_data;
          egct_pkg::CFG_OFFSET:   offset_r <= cfg_data;
          egct_pkg::CFG_DIRECT:   direct_r <= cfg_data;
          egct_pkg::CFG_ATTACK:   am_r     <= cfg_data[0];
          egct_pkg::CFG_REL_MODE: rm_r     <= cfg_data[1:0];
          egct_pkg::CFG_REL_BASE: rb_r     <= cfg_data[4:0];
          default: ;
        endcase
      end
      tc_r <= tc_nxt; seg_r <= seg_nxt; csel_r <= csel_nxt; start_r <= start_nxt;
      target_r <= target_nxt; cur_r <= cur_nxt; phase_r <= phase_nxt;
      hops_r <= hops_nxt; div_cnt_r <= div_cnt_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; p_r <= p_nxt; rem_r <= rem_nxt; divd_r <= divd_nxt;
    w_r <= w_nxt; sat_r <= sat_nxt;
    if (cmd.op == egct_pkg::OP_LATCH) begin
      cmd_r <= egct_pkg::cmd_t'(in_cmd); tick_r <= in_tick_amount;
      pidx_r <= in_point_index; pkind_r <= in_point_kind;
      pdur_r <= in_point_duration; plvl_r <= in_point_level;
    end
    if (cmd.op == egct_pkg::OP_EMIT) begin
      out_level_r <= sat_r;
      out_phase_r <= phase_r;
    end
  end

  assign stat.cmd          = cmd_r;
  assign stat.phase        = phase_r;
  assign stat.attack_mode  = am_r;
  assign stat.release_mode = rm_r;
  assign stat.direct_nz    = direct_r != '0;
  assign stat.rel_tabled   = rel_tabled;
  assign stat.tabled       = (phase_r == egct_pkg::PH_ATTACK) ? am_r : rel_tabled;
  assign stat.dir_live     = tc_r < {2'b00, dir_x, 16'h0000};
  assign stat.walk_go      = (hops_r < egct_pkg::HOP_W'(egct_pkg::MAX_HOPS)) &&
                             (tc_r >= {1'b0, rd.dur, 16'h0000});
  assign stat.rd_kind      = rd.kind;
  assign stat.div_clamp    = tc_r >= {1'b0, divd_r, 16'h0000};
  assign stat.div_last     = div_cnt_r == 4'd15;
  assign stat.out_free     = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

endmodule
